// ===== src/long_press_button_monitor_top_defines.svh =====
// assertion macros shared by the button monitor rtl
// needs a clk and rst (synchronous, active high) in the including module
`ifndef LONG_PRESS_BUTTON_MONITOR_TOP_DEFINES_SVH
`define LONG_PRESS_BUTTON_MONITOR_TOP_DEFINES_SVH

// property that must hold at every edge outside reset
`define LPBM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// when ante holds, cons must hold in the next cycle
`define LPBM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/lpbm_pkg.sv =====
// shared types and codes for the long press button monitor
// no dependencies
package lpbm_pkg;

  localparam logic [1:0] LED_OFF  = 2'd0;
  localparam logic [1:0] LED_ON   = 2'd1;
  localparam logic [1:0] LED_FAST = 2'd2;

  localparam logic [2:0] OUT_DECIDING = 3'd0;
  localparam logic [2:0] OUT_NOT_HELD = 3'd1;
  localparam logic [2:0] OUT_SHORT    = 3'd2;
  localparam logic [2:0] OUT_RESTORE  = 3'd3;
  localparam logic [2:0] OUT_TOO_LONG = 3'd4;

  localparam logic [2:0] REG_BUTTON_PRESENT = 3'd0;
  localparam logic [2:0] REG_MIN_HOLD       = 3'd1;
  localparam logic [2:0] REG_MAX_HOLD       = 3'd2;
  localparam logic [2:0] REG_BLINK          = 3'd3;
  localparam logic [2:0] REG_PAUSE          = 3'd4;

  localparam logic        RST_BUTTON_PRESENT = 1'b1;
  localparam logic [31:0] RST_MIN_HOLD       = 32'd1000;
  localparam logic [31:0] RST_MAX_HOLD       = 32'd3000;
  localparam logic [15:0] RST_BLINK          = 16'd10;
  localparam logic [15:0] RST_PAUSE          = 16'd50;

  localparam int WORD_W = 6;

  typedef enum logic [2:0] {
    PH_FIRST = 3'b001,
    PH_HOLD  = 3'b010,
    PH_DONE  = 3'b100
  } phase_t;

  typedef struct packed {
    logic        button_present;
    logic [31:0] hold_min;
    logic [31:0] hold_max;
    logic [15:0] blink_len;
    logic [15:0] pause_len;
  } cfg_t;

  // packed low bit first: led_mode, outcome, finished
  typedef struct packed {
    logic       finished;
    logic [2:0] outcome;
    logic [1:0] led_mode;
  } result_t;

endpackage

// ===== src/long_press_button_monitor_top.sv =====
// top level of the long press button monitor: config registers, tick logic, output buffer
// depends on lpbm_pkg, lpbm_core and lpbm_obuf
//
// Boot-time reset button monitor. Every input word is one system tick with the sampled
// button level and gives exactly one result word: led drive, outcome code and a finished
// flag. A word is taken on every cycle while the two-word output buffer has room, so the
// block runs at one tick per clock; the tick logic is combinational compare and
// saturating-increment logic feeding that buffer. Back pressure on the output stalls the
// input only once both buffer words are occupied. Register writes go through wr_en,
// wr_index and wr_data and apply to the next accepted tick; indexes beyond the register
// list are ignored.
module long_press_button_monitor_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // [0] button_pressed, [7:1] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,    // [1:0] led_mode, [4:2] outcome, [5] finished, [7:6] zero
  input  logic        wr_en,
  input  logic [2:0]  wr_index,
  input  logic [31:0] wr_data
);

  lpbm_pkg::cfg_t    cfg;
  lpbm_pkg::result_t result;
  logic              accept;
  logic [lpbm_pkg::WORD_W-1:0] buf_data;

  // configuration registers, written while the block is idle: a rule for the user, not enforced by the block
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.button_present <= lpbm_pkg::RST_BUTTON_PRESENT;
      cfg.hold_min       <= lpbm_pkg::RST_MIN_HOLD;
      cfg.hold_max       <= lpbm_pkg::RST_MAX_HOLD;
      cfg.blink_len      <= lpbm_pkg::RST_BLINK;
      cfg.pause_len      <= lpbm_pkg::RST_PAUSE;
    end else if (wr_en) begin
      unique case (wr_index)
        lpbm_pkg::REG_BUTTON_PRESENT: cfg.button_present <= wr_data[0];
        lpbm_pkg::REG_MIN_HOLD:       cfg.hold_min       <= wr_data;
        lpbm_pkg::REG_MAX_HOLD:       cfg.hold_max       <= wr_data;
        lpbm_pkg::REG_BLINK:          cfg.blink_len      <= wr_data[15:0];
        lpbm_pkg::REG_PAUSE:          cfg.pause_len      <= wr_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // a tick is consumed whenever the result buffer can take its word
  assign accept = s_tvalid && s_tready;

  lpbm_core u_core (
    .clk            (clk),
    .rst            (rst),
    .accept         (accept),
    .button_pressed (s_tdata[0]),
    .cfg            (cfg),
    .result         (result)
  );

  lpbm_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_data  (result),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (buf_data)
  );

  assign m_tdata = {2'b00, buf_data};

endmodule

// ===== src/lpbm_core.sv =====
// hold tracking and blink sequencing, one tick per accepted word
// depends on lpbm_pkg
module lpbm_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              button_pressed,
  input  lpbm_pkg::cfg_t    cfg,
  output lpbm_pkg::result_t result
);

  lpbm_pkg::phase_t phase, phase_next;
  logic [31:0] elapsed_ticks, elapsed_ticks_next, elapsed_inc;
  logic [15:0] since_step, since_step_next, since_inc, phase_len;
  logic [1:0]  blink_phase, blink_phase_next, pattern_step;
  logic [1:0]  led_state, led_state_next;
  logic [2:0]  final_outcome, final_outcome_next;

  // saturating counters
  assign elapsed_inc  = elapsed_ticks + 32'(~&elapsed_ticks);
  assign since_inc    = since_step + 16'(~&since_step);
  assign phase_len    = (blink_phase == 2'd3) ? cfg.pause_len : cfg.blink_len;
  assign pattern_step = blink_phase + 2'd1;

  always_comb begin
    phase_next         = phase;
    elapsed_ticks_next = elapsed_ticks;
    since_step_next    = since_step;
    blink_phase_next   = blink_phase;
    led_state_next     = led_state;
    final_outcome_next = final_outcome;
    unique case (phase)
      lpbm_pkg::PH_FIRST: begin
        if (!cfg.button_present || !button_pressed) begin
          final_outcome_next = lpbm_pkg::OUT_NOT_HELD;
          phase_next         = lpbm_pkg::PH_DONE;
        end else begin
          led_state_next     = lpbm_pkg::LED_ON;
          elapsed_ticks_next = '0;
          since_step_next    = '0;
          blink_phase_next   = '0;
          final_outcome_next = lpbm_pkg::OUT_DECIDING;
          phase_next         = lpbm_pkg::PH_HOLD;
        end
      end
      lpbm_pkg::PH_HOLD: begin
        elapsed_ticks_next = elapsed_inc;
        since_step_next    = since_inc;
        if (!button_pressed) begin
          phase_next = lpbm_pkg::PH_DONE;
          if (elapsed_inc >= cfg.hold_min) begin
            led_state_next     = lpbm_pkg::LED_FAST;
            final_outcome_next = lpbm_pkg::OUT_RESTORE;
          end else begin
            led_state_next     = lpbm_pkg::LED_ON;
            final_outcome_next = lpbm_pkg::OUT_SHORT;
          end
        end else if (elapsed_inc > cfg.hold_max) begin
          final_outcome_next = lpbm_pkg::OUT_TOO_LONG;
          phase_next         = lpbm_pkg::PH_DONE;
        end else if (since_inc >= phase_len) begin
          // even steps of the pattern light the led
          blink_phase_next = pattern_step;
          led_state_next   = pattern_step[0] ? lpbm_pkg::LED_OFF : lpbm_pkg::LED_ON;
          since_step_next  = '0;
        end
      end
      lpbm_pkg::PH_DONE: begin
      end
      default: begin
        phase_next = lpbm_pkg::PH_DONE;
      end
    endcase
  end

  assign result.led_mode = led_state_next;
  assign result.outcome  = final_outcome_next;
  assign result.finished = (phase_next == lpbm_pkg::PH_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= lpbm_pkg::PH_FIRST;
      elapsed_ticks <= '0;
      since_step    <= '0;
      blink_phase   <= '0;
      led_state     <= lpbm_pkg::LED_OFF;
      final_outcome <= lpbm_pkg::OUT_DECIDING;
    end else if (accept) begin
      phase         <= phase_next;
      elapsed_ticks <= elapsed_ticks_next;
      since_step    <= since_step_next;
      blink_phase   <= blink_phase_next;
      led_state     <= led_state_next;
      final_outcome <= final_outcome_next;
    end
  end

endmodule

// ===== src/lpbm_obuf.sv =====
// two-word result buffer between the tick logic and the output stream
// depends on lpbm_pkg and the shared assertion macros
`include "long_press_button_monitor_top_defines.svh"

module lpbm_obuf (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [lpbm_pkg::WORD_W-1:0]   in_data,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [lpbm_pkg::WORD_W-1:0]   m_tdata
);

  logic [lpbm_pkg::WORD_W-1:0] mem [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign in_ready = (count != 2'd2);
  assign m_tvalid = (count != 2'd0);
  assign m_tdata  = mem[rd_ptr];
  assign push     = in_valid && in_ready;
  assign pop      = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  `LPBM_ASSERT(a_count_range, count != 2'd3, "result buffer count out of range")
  `LPBM_ASSERT(a_ptr_track, (count == 2'd1) == (wr_ptr != rd_ptr), "buffer pointers disagree with count")
  `LPBM_ASSERT_NEXT(a_push_only, push && !pop, count == $past(count) + 2'd1, "push lost in buffer")

endmodule
